// ===== hw/rtl/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// phc_pkg
// shared types, constants and helpers of the pooled handle cache
// ----------------------------------------------------------------------------
package phc_pkg;

	localparam int DEPTH       = 64;
	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = AW + 1;
	localparam int HANDLE_BITS = 32;
	localparam int MIN_FREE    = 32;

	typedef enum logic [1:0] {
		KIND_GRANT    = 2'd0,
		KIND_CREATE   = 2'd1,
		KIND_RELEASE  = 2'd2,
		KIND_PUT_DONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_HIGH_WATER = 2'd0,
		REG_LOW_WATER  = 2'd1,
		REG_MAX_IDLE   = 2'd2,
		REG_WASH_GAP   = 2'd3
	} reg_idx_t;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] now_ticks;
		logic [31:0] handle_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] handle_out;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [6:0]  trim_level;
		logic [6:0]  keep_level;
		logic [31:0] max_idle_ticks;
		logic [15:0] min_wash_interval;
	} cfg_t;

	typedef struct packed {
		logic                   we;
		logic [AW:0]            waddr;
		logic [HANDLE_BITS-1:0] wdata;
		logic                   re;
		logic [AW:0]            raddr;
	} hreq_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [31:0]   wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} treq_t;

	// min(x, max(x/2, MIN_FREE))
	function automatic logic [CW-1:0] trim_count(input logic [CW-1:0] x);
		logic [CW-1:0] half;
		logic [CW-1:0] m;
		half = x >> 1;
		m    = (half > CW'(MIN_FREE)) ? half : CW'(MIN_FREE);
		return (x < m) ? x : m;
	endfunction

endpackage

// ===== hw/rtl/phc_ram.sv =====
// ----------------------------------------------------------------------------
// phc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module phc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/phc_ctrl.sv =====
// ----------------------------------------------------------------------------
// phc_ctrl
// sequencer for get, put, bank swap and wash over the handle and time memories
// ----------------------------------------------------------------------------
module phc_ctrl import phc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data,
	output hreq_t                  hreq,
	input  logic [HANDLE_BITS-1:0] hrdata,
	output treq_t                  treq,
	input  logic [31:0]            trdata
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_SWAP, ST_POP_RD, ST_POP_OUT, ST_WASH,
		ST_TRIM_RD, ST_TRIM_WR, ST_SCAN_RD, ST_SCAN_CHK, ST_FINISH
	} state_t;

	state_t                 state_q;
	in_item_t               item_q;
	logic [AW-1:0]          head_q;
	logic [CW-1:0]          pcnt_q;
	logic [CW-1:0]          scnt_q;
	logic                   sel_q;
	logic [31:0]            lwt_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic                   phase_q;
	logic                   skip_q;
	logic                   pend_valid_q;
	logic [HANDLE_BITS-1:0] pend_h_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic          push_ok;
	logic          keep;
	logic [AW-1:0] tail_idx;
	logic [31:0]   wash_age;
	logic [CW-1:0] excess;

	assign push_ok   = !out_valid_q || out_ready;
	assign keep      = (scnt_q < cfg.keep_level) && (scnt_q < CW'(DEPTH));
	assign tail_idx  = head_q + pcnt_q[AW-1:0];
	assign wash_age  = item_q.now_ticks - lwt_q;
	assign excess    = pcnt_q - cfg.trim_level;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		hreq = '0;
		treq = '0;
		unique case (state_q)
			ST_START: begin
				if (item_q.operation == OP_PUT && pcnt_q < CW'(DEPTH)) begin
					hreq.we    = 1'b1;
					hreq.waddr = {sel_q, tail_idx};
					hreq.wdata = item_q.handle_in[HANDLE_BITS-1:0];
					treq.we    = 1'b1;
					treq.waddr = tail_idx;
					treq.wdata = item_q.now_ticks;
				end
			end
			ST_SWAP: begin
				treq.we    = (idx_q < pcnt_q);
				treq.waddr = idx_q[AW-1:0];
				treq.wdata = item_q.now_ticks;
			end
			ST_POP_RD: begin
				hreq.re    = 1'b1;
				hreq.raddr = {sel_q, tail_idx - AW'(1)};
			end
			ST_TRIM_RD: begin
				hreq.re    = (cnt_q != '0) && (pcnt_q != '0);
				hreq.raddr = {sel_q, head_q};
			end
			ST_TRIM_WR: begin
				hreq.we    = keep;
				hreq.waddr = {~sel_q, scnt_q[AW-1:0]};
				hreq.wdata = hrdata;
			end
			ST_SCAN_RD: begin
				treq.re    = (idx_q < pcnt_q);
				treq.raddr = head_q + idx_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			pcnt_q       <= '0;
			scnt_q       <= '0;
			sel_q        <= 1'b0;
			lwt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
			idx_q        <= '0;
			phase_q      <= 1'b0;
			skip_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (item_q.operation == OP_PUT) begin
						if (pcnt_q >= CW'(DEPTH)) begin
							pend_valid_q <= 1'b1;
							pend_h_q     <= item_q.handle_in[HANDLE_BITS-1:0];
						end else begin
							pcnt_q <= pcnt_q + CW'(1);
						end
						state_q <= ST_WASH;
					end else if (pcnt_q == '0 && scnt_q == '0) begin
						if (push_ok) begin
							out_valid_q <= 1'b1;
							out_q       <= '{kind: KIND_CREATE, handle_out: '0, last: 1'b1};
							state_q     <= ST_IDLE;
						end
					end else if (pcnt_q == '0) begin
						sel_q   <= ~sel_q;
						head_q  <= '0;
						pcnt_q  <= scnt_q;
						scnt_q  <= '0;
						idx_q   <= '0;
						state_q <= ST_SWAP;
					end else begin
						state_q <= ST_POP_RD;
					end
				end
				ST_SWAP: begin
					if (idx_q < pcnt_q) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= ST_POP_RD;
					end
				end
				ST_POP_RD: begin
					pcnt_q  <= pcnt_q - CW'(1);
					state_q <= ST_POP_OUT;
				end
				ST_POP_OUT: begin
					if (push_ok) begin
						out_valid_q <= 1'b1;
						out_q       <= '{kind: KIND_GRANT, handle_out: 32'(hrdata), last: 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				ST_WASH: begin
					if (wash_age < {16'd0, cfg.min_wash_interval}) begin
						state_q <= ST_FINISH;
					end else begin
						lwt_q <= item_q.now_ticks;
						if (pcnt_q > cfg.trim_level) begin
							cnt_q   <= trim_count(excess);
							skip_q  <= (trim_count(excess) == CW'(MIN_FREE));
							phase_q <= 1'b0;
							state_q <= ST_TRIM_RD;
						end else begin
							idx_q   <= '0;
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_TRIM_RD: begin
					if (cnt_q == '0 || pcnt_q == '0) begin
						if (!phase_q && !skip_q) begin
							idx_q   <= '0;
							state_q <= ST_SCAN_RD;
						end else begin
							state_q <= ST_FINISH;
						end
					end else begin
						state_q <= ST_TRIM_WR;
					end
				end
				ST_TRIM_WR: begin
					if (keep || !pend_valid_q || push_ok) begin
						if (keep) begin
							scnt_q <= scnt_q + CW'(1);
						end else begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_q       <= '{kind: KIND_RELEASE,
									handle_out: 32'(pend_h_q), last: 1'b0};
							end
							pend_valid_q <= 1'b1;
							pend_h_q     <= hrdata;
						end
						head_q  <= head_q + AW'(1);
						pcnt_q  <= pcnt_q - CW'(1);
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_TRIM_RD;
					end
				end
				ST_SCAN_RD: begin
					if (idx_q < pcnt_q) begin
						state_q <= ST_SCAN_CHK;
					end else begin
						cnt_q   <= trim_count(idx_q);
						phase_q <= 1'b1;
						state_q <= ST_TRIM_RD;
					end
				end
				ST_SCAN_CHK: begin
					if ((item_q.now_ticks - trdata) < cfg.max_idle_ticks) begin
						cnt_q   <= trim_count(idx_q);
						phase_q <= 1'b1;
						state_q <= ST_TRIM_RD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_FINISH: begin
					if (push_ok) begin
						out_valid_q <= 1'b1;
						if (pend_valid_q) begin
							out_q <= '{kind: KIND_RELEASE, handle_out: 32'(pend_h_q), last: 1'b1};
						end else begin
							out_q <= '{kind: KIND_PUT_DONE, handle_out: '0, last: 1'b1};
						end
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/pooled_handle_cache_with_idle_wash.sv =====
// ----------------------------------------------------------------------------
// pooled_handle_cache_with_idle_wash
// two-level free handle cache with timestamped primary ring, secondary bank
// and a rate-limited wash of old and idle entries
//
//   channel   signals                          direction
//   in        in_valid, in_ready, in_data      get or put request
//   out       out_valid, out_ready, out_data   grant, create, release, done
//   cfg       cfg_we, cfg_addr, cfg_wdata      register write, no read-back
//
// one transaction at a time: a get answers create when both levels are
// empty, and swaps the secondary bank in first when the primary is empty
// (one time-memory write per entry)
// a put scans and trims entries one at a time, each with a read state and
// a check or write state, set by the single read port of each memory
// output stalls hold the sequencer; reset clears counters, loads default config, no memory pass
// ----------------------------------------------------------------------------
module pooled_handle_cache_with_idle_wash import phc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [31:0] cfg_wdata
);

	cfg_t                   cfg_q;
	hreq_t                  hreq;
	treq_t                  treq;
	logic [HANDLE_BITS-1:0] hrdata;
	logic [31:0]            trdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trim_level        <= 7'd16;
			cfg_q.keep_level        <= 7'd8;
			cfg_q.max_idle_ticks    <= 32'd10000;
			cfg_q.min_wash_interval <= 16'd5;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_HIGH_WATER: cfg_q.trim_level        <= cfg_wdata[6:0];
				REG_LOW_WATER:  cfg_q.keep_level        <= cfg_wdata[6:0];
				REG_MAX_IDLE:   cfg_q.max_idle_ticks    <= cfg_wdata;
				REG_WASH_GAP:   cfg_q.min_wash_interval <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	phc_ram #(.WIDTH(HANDLE_BITS), .DEPTH(2 * DEPTH)) u_handles (
		.clk   (clk),
		.we    (hreq.we),
		.waddr (hreq.waddr),
		.wdata (hreq.wdata),
		.re    (hreq.re),
		.raddr (hreq.raddr),
		.rdata (hrdata)
	);

	phc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_times (
		.clk   (clk),
		.we    (treq.we),
		.waddr (treq.waddr),
		.wdata (treq.wdata),
		.re    (treq.re),
		.raddr (treq.raddr),
		.rdata (trdata)
	);

	phc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.hreq      (hreq),
		.hrdata    (hrdata),
		.treq      (treq),
		.trdata    (trdata)
	);

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the pooled handle cache: gets and puts are driven
// through valid/ready with random gaps, every result is compared against an
// in-bench model of the primary ring, secondary bank and wash
// ----------------------------------------------------------------------------
module tb;
	import phc_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [1:0] cfg_addr;
	logic [31:0] cfg_wdata;

	pooled_handle_cache_with_idle_wash u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// cache model
	logic [31:0] m_handles [0:2*DEPTH-1];
	logic [31:0] m_times   [0:DEPTH-1];
	int unsigned m_head, m_pcount, m_scount, m_sel;
	logic [31:0] m_last_wash;
	logic [6:0]  m_hwm, m_lwm;
	logic [31:0] m_idle;
	logic [15:0] m_gap;
	int          n_rel;

	out_item_t   expected_q [$];
	int          n_items, n_results, n_mismatch;
	int          stall_hold;
	logic [31:0] now_cnt;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned pb();
		return m_sel ? DEPTH : 0;
	endfunction

	function automatic int unsigned sb();
		return m_sel ? 0 : DEPTH;
	endfunction

	function automatic int unsigned trim_of(int unsigned x);
		int unsigned half, m;
		half = x / 2;
		m = (half > MIN_FREE) ? half : MIN_FREE;
		return (x < m) ? x : m;
	endfunction

	function automatic void push_result(kind_t k, logic [31:0] h, logic l);
		out_item_t r;
		r.kind = k;
		r.handle_out = h;
		r.last = l;
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void release_handle(logic [31:0] h);
		push_result(KIND_RELEASE, h, 1'b0);
		n_rel++;
	endfunction

	function automatic void trim_oldest(int unsigned cnt);
		logic [31:0] h;
		while (cnt > 0 && m_pcount > 0) begin
			h = m_handles[pb() + m_head];
			if (m_scount < m_lwm && m_scount < DEPTH) begin
				m_handles[sb() + m_scount] = h;
				m_scount++;
			end else
				release_handle(h);
			m_head = (m_head + 1) % DEPTH;
			m_pcount--;
			cnt--;
		end
	endfunction

	function automatic void wash_pass(logic [31:0] now);
		int unsigned idle, upto;
		logic [31:0] d;
		idle = 0;
		d = now - m_last_wash;
		if (d < {16'd0, m_gap}) return;
		m_last_wash = now;
		if (m_pcount > m_hwm) begin
			upto = trim_of(m_pcount - m_hwm);
			trim_oldest(upto);
			if (upto == MIN_FREE) return;
		end
		while (idle < m_pcount) begin
			d = now - m_times[(m_head + idle) % DEPTH];
			if (d < m_idle) break;
			idle++;
		end
		trim_oldest(trim_of(idle));
	endfunction

	function automatic void predict_cache(in_item_t it);
		int unsigned idx;
		n_rel = 0;
		if (it.operation == OP_GET) begin
			if (m_pcount == 0) begin
				if (m_scount == 0) begin
					push_result(KIND_CREATE, 32'd0, 1'b1);
					return;
				end
				m_sel ^= 1;
				m_head = 0;
				m_pcount = m_scount;
				m_scount = 0;
				for (int i = 0; i < m_pcount; i++) m_times[i] = it.now_ticks;
			end
			idx = (m_head + m_pcount - 1) % DEPTH;
			m_pcount--;
			push_result(KIND_GRANT, m_handles[pb() + idx], 1'b1);
			return;
		end
		if (m_pcount >= DEPTH)
			release_handle(it.handle_in);
		else begin
			idx = (m_head + m_pcount) % DEPTH;
			m_handles[pb() + idx] = it.handle_in;
			m_times[idx] = it.now_ticks;
			m_pcount++;
		end
		wash_pass(it.now_ticks);
		if (n_rel == 0)
			push_result(KIND_PUT_DONE, 32'd0, 1'b1);
		else
			expected_q[expected_q.size()-1].last = 1'b1;
	endfunction

	// receiver: a wait drawn per result, plus long stalls on request
	initial begin
		int w;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			while (w > 0 || stall_hold > 0) begin
				@(negedge clk);
				out_ready <= 0;
				if (stall_hold > 0) stall_hold--;
				else w--;
			end
			@(negedge clk);
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result %p", out_data);
			end else begin
				out_item_t e;
				e = expected_q[0];
				expected_q.delete(0);
				if (out_data.kind !== e.kind || out_data.handle_out !== e.handle_out ||
						out_data.last !== e.last) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: expected %p actual %p", e, out_data);
				end
			end
		end
	end

	task automatic send_item(logic op, logic [31:0] now, logic [31:0] h);
		in_item_t it;
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
		repeat (gap) @(negedge clk);
		it.operation = op;
		it.now_ticks = now;
		it.handle_in = h;
		in_data <= it;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_cache(it);
		n_items++;
		@(negedge clk);
		in_valid <= 0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= r;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		case (r)
			REG_HIGH_WATER: m_hwm = v[6:0];
			REG_LOW_WATER:  m_lwm = v[6:0];
			REG_MAX_IDLE:   m_idle = v;
			REG_WASH_GAP:   m_gap = v[15:0];
		endcase
	endtask

	task automatic set_cfg(logic [6:0] h, logic [6:0] l, logic [31:0] i, logic [15:0] g);
		wait_idle();
		write_reg(REG_HIGH_WATER, {25'd0, h});
		write_reg(REG_LOW_WATER, {25'd0, l});
		write_reg(REG_MAX_IDLE, i);
		write_reg(REG_WASH_GAP, {16'd0, g});
	endtask

	task automatic test_directed();
		send_item(OP_GET, 32'd0, 32'hFFFF_FFFF);
		send_item(OP_PUT, 32'd10, 32'hFFFF_FFFF);
		send_item(OP_PUT, 32'd11, 32'h0000_0000);
		send_item(OP_GET, 32'd12, 32'h1234_5678);
		send_item(OP_GET, 32'd13, 32'h0);
		send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
		set_cfg(7'd2, 7'd4, 32'd100, 16'd0);
		for (int i = 0; i < 6; i++) send_item(OP_PUT, 32'd100 + i, 32'hA000_0000 + i);
		send_item(OP_PUT, 32'd5000, 32'hA5A5_A5A5);
		for (int i = 0; i < 5; i++) send_item(OP_GET, 32'd6000, 32'h0);
	endtask

	// fill the primary to the top, then saturate it
	task automatic test_saturation();
		set_cfg(7'd64, 7'd64, 32'hFFFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 66; i++) send_item(OP_PUT, 32'd7, 32'h5000_0000 + i);
		set_cfg(7'd0, 7'd64, 32'hFFFF_FFFF, 16'd0);
		send_item(OP_PUT, 32'd70000, 32'h5555_AAAA);
		set_cfg(7'd0, 7'd0, 32'd0, 16'd0);
		send_item(OP_PUT, 32'd70001, 32'hAAAA_5555);
		for (int i = 0; i < 4; i++) send_item(OP_GET, 32'd70002, 32'h0);
	endtask

	task automatic test_backpressure();
		set_cfg(7'd4, 7'd2, 32'd50, 16'd1);
		stall_hold = 400;
		for (int i = 0; i < 20; i++) send_item(OP_PUT, now_cnt + i * 3, $urandom());
		now_cnt += 100;
	endtask

	task automatic test_random();
		logic op;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: set_cfg(7'd16, 7'd8, 32'd10000, 16'd5);
				1: set_cfg(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
						$urandom_range(1, 400), 16'($urandom_range(0, 20)));
				default: set_cfg(7'd127, 7'd127, 32'd30, 16'd0);
			endcase
			for (int i = 0; i < 14; i++) begin
				op = ($urandom_range(0, 99) < 60) ? OP_PUT : OP_GET;
				now_cnt += $urandom_range(0, 40);
				if ($urandom_range(0, 19) == 0) now_cnt = $urandom();
				send_item(op, now_cnt, $urandom());
			end
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_addr = REG_HIGH_WATER;
		cfg_wdata = '0;
		n_items = 0;
		n_results = 0;
		n_mismatch = 0;
		stall_hold = 0;
		now_cnt = 32'd1000;
		m_head = 0; m_pcount = 0; m_scount = 0; m_sel = 0;
		m_last_wash = 0;
		m_hwm = 16; m_lwm = 8; m_idle = 10000; m_gap = 5;
		repeat (6) @(negedge clk);
		arst_n = 1;
		test_directed();
		test_saturation();
		test_backpressure();
		test_random();
		wait_idle();
		$display("sent %0d gets and puts, checked %0d results, %0d mismatches",
			n_items, n_results, n_mismatch);
		if (n_mismatch == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
